>>> src/vtyp_pkg.sv
// Shared constants, types and the arctangent step table for the yaw/pitch pipeline.
`timescale 1ns / 1ps
`default_nettype none

package vtyp_pkg;

  // Magnitudes enter the first rotation stage shifted up by this many guard bits.
  localparam int GUARD = 24;

  // CORDIC gain in Q30, used to scale |z| to the length that the first rotation returns.
  localparam int KGAIN_W = 31;
  localparam logic [KGAIN_W-1:0] KGAIN_Q30 = 31'd1768195363;
  localparam int KGAIN_SHIFT = 30 - GUARD;
  localparam int ZK_HALF = 2 ** (29 - GUARD);

  // Angles count in units of 1e-10 degree; 42 bits cover a full turn.
  localparam int ANG_W = 42;
  localparam logic [ANG_W-1:0] DEG_90  = 42'd900000000000;
  localparam logic [ANG_W-1:0] DEG_180 = 42'd1800000000000;
  localparam logic [ANG_W-1:0] DEG_270 = 42'd2700000000000;
  localparam logic [ANG_W-1:0] DEG_360 = 42'd3600000000000;

  localparam logic [63:0] E10 = 64'd10000000000;
  localparam logic [63:0] DEG_PER_RAD_E10 = 64'd572957795131;

  // atan(2^-i) in 1e-10 degree for the first sixteen rotations.
  localparam logic [63:0] ATAN_TAB [16] = '{
    64'd450000000000, 64'd265650511771, 64'd140362434679, 64'd71250163489,
    64'd35763343750,  64'd17899106082,  64'd8951737102,   64'd4476141709,
    64'd2238105004,   64'd1119056771,   64'd559528919,    64'd279764526,
    64'd139882271,    64'd69941137,     64'd34970569,     64'd17485284
  };

  // Sign and zero information that travels beside the datapath.
  typedef struct packed {
    logic xn;
    logic yn;
    logic zn;
    logic x_zero;
    logic xy_zero;
    logic z_pos;
  } vtyp_flags_t;

  // Rotation angle of stage i; beyond the table, atan(2^-i) is taken as 2^-i radians.
  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
    logic [63:0] v;
    if (i < 16) begin
      v = ATAN_TAB[i[3:0]];
    end else begin
      v = (DEG_PER_RAD_E10 + (64'd1 << (i - 1))) >> i;
    end
    return $signed(v[ANG_W-1:0]);
  endfunction

endpackage

`default_nettype wire

>>> src/vtyp_if.sv
// Handshake interfaces for the direction vector input and the angle result output.
`timescale 1ns / 1ps
`default_nettype none

interface vtyp_dir_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface vtyp_ang_if #(
  parameter int ANGLE_FRAC_BITS = 8
);
  logic                               valid;
  logic                               ready;
  logic        [9+ANGLE_FRAC_BITS-1:0]  yaw_deg;
  logic signed [10+ANGLE_FRAC_BITS-1:0] neg_pitch_deg;

  modport source (output valid, output yaw_deg, output neg_pitch_deg, input ready);
  modport sink   (input valid, input yaw_deg, input neg_pitch_deg, output ready);
endinterface

`default_nettype wire

>>> src/vector_to_yaw_pitch.sv
// Top level: direction vector in, yaw and negated pitch in fixed-point degrees out.
//
// Usage: a vector (dir_x, dir_y, dir_z) enters on in_ch when valid and ready are both
// high; one result (yaw_deg, neg_pitch_deg) leaves on out_ch for every vector, in order.
// Angles are in units of 2^-ANGLE_FRAC_BITS degree; yaw lies in [0, 360) and the
// negated pitch in (-360, 0]. No state is kept between vectors.
// Throughput: one vector per cycle while no stall freezes the pipeline. From acceptance,
// a vector passes the front end, the two chained CORDIC pipelines (yaw, then pitch
// against the horizontal length), the four-stage rounding division into degrees
// (reciprocal estimate, then a remainder correction) and the output register.
// Reset (rst_n low, synchronous) clears every valid bit, so the pipeline and the output
// register come up empty; the datapath registers are not reset.
// Stalls: the output register is backed by a one-item skid register. While out_ch.ready
// is low the pipeline keeps moving until the skid register fills; only then does the
// whole pipeline freeze and in_ch.ready fall. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module vector_to_yaw_pitch
  import vtyp_pkg::*;
#(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  vtyp_dir_if.sink    in_ch,
  vtyp_ang_if.source  out_ch
);

  localparam int C   = COORD_BITS;
  localparam int CW  = COORD_BITS + 28;
  localparam int PW  = COORD_BITS + KGAIN_W;
  localparam int FW  = $bits(vtyp_flags_t);
  localparam int SWA = PW + FW;
  localparam int SWB = ANG_W + FW;
  localparam int QW  = 9 + ANGLE_FRAC_BITS;
  localparam int OW  = 10 + ANGLE_FRAC_BITS;
  localparam int TURN = 360 * (2 ** ANGLE_FRAC_BITS);

  logic                 pipe_en;
  logic                 out_fire;
  logic                 leave;

  logic                 fe_v;
  logic [C-1:0]         fe_ax;
  logic [C-1:0]         fe_ay;
  logic [PW-1:0]        fe_zprod;
  vtyp_flags_t          fe_flags;

  logic signed [CW-1:0] ca_x;
  logic signed [CW-1:0] ca_y;
  logic [SWA-1:0]       ca_side_in;
  logic                 ca_v;
  logic [ANG_W-1:0]     ca_ang;
  logic signed [CW-1:0] ca_mag;
  logic [SWA-1:0]       ca_side;
  logic [PW-1:0]        ca_zprod;
  vtyp_flags_t          ca_flags;

  logic [PW:0]          zsum;
  logic [ANG_W-1:0]     yaw_e_nxt;
  logic                 c1_v_r;
  logic [ANG_W-1:0]     c1_yaw_e_r;
  logic signed [CW-1:0] c1_zk_r;
  logic signed [CW-1:0] c1_h_r;
  vtyp_flags_t          c1_flags_r;

  logic                 cb_v;
  logic [ANG_W-1:0]     cb_ang;
  logic [SWB-1:0]       cb_side;
  logic [ANG_W-1:0]     cb_yaw_e;
  vtyp_flags_t          cb_flags;

  logic [ANG_W-1:0]     pitch_e_nxt;
  logic                 c2_v_r;
  logic [ANG_W-1:0]     c2_yaw_e_r;
  logic [ANG_W-1:0]     c2_pitch_e_r;

  logic                 do_v;
  logic [QW-1:0]        do_yaw;
  logic signed [OW-1:0] do_negp;

  logic                 out_v_r;
  logic [QW-1:0]        yaw_r;
  logic signed [OW-1:0] negp_r;
  logic                 skid_v_r;
  logic [QW-1:0]        skid_yaw_r;
  logic signed [OW-1:0] skid_negp_r;

  // The pipeline only freezes when the skid register already holds an item.
  assign pipe_en     = !skid_v_r;
  assign out_fire    = out_v_r && out_ch.ready;
  assign leave       = pipe_en && do_v;
  assign in_ch.ready = pipe_en;

  vtyp_front #(
    .C (C)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_v      (in_ch.valid),
    .dir_x     (in_ch.dir_x),
    .dir_y     (in_ch.dir_y),
    .dir_z     (in_ch.dir_z),
    .out_v     (fe_v),
    .out_ax    (fe_ax),
    .out_ay    (fe_ay),
    .out_zprod (fe_zprod),
    .out_flags (fe_flags)
  );

  // Yaw rotation on |x| and |y| with guard bits; its final x is the scaled horizontal length.
  assign ca_x       = CW'({fe_ax, {GUARD{1'b0}}});
  assign ca_y       = CW'({fe_ay, {GUARD{1'b0}}});
  assign ca_side_in = {fe_zprod, fe_flags};

  vtyp_cordic #(
    .W      (CW),
    .STAGES (CORDIC_STAGES),
    .SW     (SWA)
  ) u_cordic_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (fe_v),
    .in_x     (ca_x),
    .in_y     (ca_y),
    .in_side  (ca_side_in),
    .out_v    (ca_v),
    .out_ang  (ca_ang),
    .out_mag  (ca_mag),
    .out_side (ca_side)
  );

  assign {ca_zprod, ca_flags} = ca_side;

  // Yaw by quadrant, and |z| scaled by the gain rounded half up.
  always_comb begin
    zsum = {1'b0, ca_zprod} + (PW + 1)'(ZK_HALF);
    priority if (ca_flags.xy_zero) begin
      yaw_e_nxt = '0;
    end else if (ca_flags.x_zero) begin
      yaw_e_nxt = ca_flags.yn ? DEG_270 : DEG_90;
    end else if (!ca_flags.xn) begin
      yaw_e_nxt = ca_flags.yn ? (DEG_360 - ca_ang) : ca_ang;
    end else begin
      yaw_e_nxt = ca_flags.yn ? (DEG_180 + ca_ang) : (DEG_180 - ca_ang);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
    end else if (pipe_en) begin
      c1_v_r <= ca_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c1_yaw_e_r <= yaw_e_nxt;
      c1_zk_r    <= CW'(zsum >> KGAIN_SHIFT);
      c1_h_r     <= ca_mag;
      c1_flags_r <= ca_flags;
    end
  end

  // Pitch rotation of the scaled |z| against the scaled horizontal length.
  vtyp_cordic #(
    .W      (CW),
    .STAGES (CORDIC_STAGES),
    .SW     (SWB)
  ) u_cordic_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (c1_v_r),
    .in_x     (c1_h_r),
    .in_y     (c1_zk_r),
    .in_side  ({c1_yaw_e_r, c1_flags_r}),
    .out_v    (cb_v),
    .out_ang  (cb_ang),
    .out_mag  (),
    .out_side (cb_side)
  );

  assign {cb_yaw_e, cb_flags} = cb_side;

  // Pitch by the sign of z; a vertical vector points straight up or straight down.
  always_comb begin
    priority if (cb_flags.xy_zero) begin
      pitch_e_nxt = cb_flags.z_pos ? DEG_90 : DEG_270;
    end else if (cb_flags.zn) begin
      pitch_e_nxt = DEG_360 - cb_ang;
    end else begin
      pitch_e_nxt = cb_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_v_r <= 1'b0;
    end else if (pipe_en) begin
      c2_v_r <= cb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c2_yaw_e_r   <= cb_yaw_e;
      c2_pitch_e_r <= pitch_e_nxt;
    end
  end

  vtyp_deg_out #(
    .F (ANGLE_FRAC_BITS)
  ) u_deg_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (pipe_en),
    .in_v          (c2_v_r),
    .yaw_e         (c2_yaw_e_r),
    .pitch_e       (c2_pitch_e_r),
    .out_v         (do_v),
    .out_yaw       (do_yaw),
    .out_neg_pitch (do_negp)
  );

  // Output register with a one-item skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_fire) begin
          skid_v_r <= 1'b0;
        end
      end else if (!out_v_r || out_fire) begin
        out_v_r <= leave;
      end else if (leave) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        yaw_r  <= skid_yaw_r;
        negp_r <= skid_negp_r;
      end
    end else if (!out_v_r || out_fire) begin
      if (leave) begin
        yaw_r  <= do_yaw;
        negp_r <= do_negp;
      end
    end else if (leave) begin
      skid_yaw_r  <= do_yaw;
      skid_negp_r <= do_negp;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.yaw_deg       = yaw_r;
  assign out_ch.neg_pitch_deg = negp_r;

`ifndef SYNTHESIS
  // The skid register only fills behind a waiting output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output register is empty");

  // A taken output item with the skid register full drains the skid register.
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_fire) |=> (!skid_v_r && out_v_r))
    else $error("skid register did not drain into the output register");

  // Yaw stays below a full turn.
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (yaw_r < QW'(TURN)))
    else $error("yaw at or above a full turn");

  // Negated pitch lies in the half-open range from minus a full turn to zero.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((negp_r <= 0) && (negp_r > -TURN)))
    else $error("negated pitch out of range");
`endif

endmodule

`default_nettype wire

>>> src/vtyp_front.sv
// Front end: magnitude and sign extraction, then scaling of |z| by the CORDIC gain.
`timescale 1ns / 1ps
`default_nettype none

module vtyp_front
  import vtyp_pkg::*;
#(
  parameter int C = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic signed [C-1:0]      dir_x,
  input  logic signed [C-1:0]      dir_y,
  input  logic signed [C-1:0]      dir_z,
  output logic                     out_v,
  output logic [C-1:0]             out_ax,
  output logic [C-1:0]             out_ay,
  output logic [C+KGAIN_W-1:0]     out_zprod,
  output vtyp_flags_t              out_flags
);

  localparam int PW = C + KGAIN_W;

  logic [C-1:0]       xu;
  logic [C-1:0]       yu;
  logic [C-1:0]       zu;
  vtyp_flags_t        fl_nxt;

  logic               v1_r;
  logic [C-1:0]       ax1_r;
  logic [C-1:0]       ay1_r;
  logic [C-1:0]       az1_r;
  vtyp_flags_t        fl1_r;

  logic               v2_r;
  logic [C-1:0]       ax2_r;
  logic [C-1:0]       ay2_r;
  logic [PW-1:0]      zp2_r;
  vtyp_flags_t        fl2_r;

  // Signs and zero tests straight from the input fields.
  always_comb begin
    xu = dir_x;
    yu = dir_y;
    zu = dir_z;
    fl_nxt.xn      = dir_x[C-1];
    fl_nxt.yn      = dir_y[C-1];
    fl_nxt.zn      = dir_z[C-1];
    fl_nxt.x_zero  = (xu == '0);
    fl_nxt.xy_zero = (xu == '0) && (yu == '0);
    fl_nxt.z_pos   = !dir_z[C-1] && (zu != '0);
  end

  // Stage one: absolute values. The most negative input maps onto 2^(C-1), which fits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= xu[C-1] ? ('0 - xu) : xu;
      ay1_r <= yu[C-1] ? ('0 - yu) : yu;
      az1_r <= zu[C-1] ? ('0 - zu) : zu;
      fl1_r <= fl_nxt;
    end
  end

  // Stage two: |z| times the gain in Q30; rounding follows after the first rotation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      zp2_r <= PW'(az1_r) * PW'(KGAIN_Q30);
      fl2_r <= fl1_r;
    end
  end

  assign out_v     = v2_r;
  assign out_ax    = ax2_r;
  assign out_ay    = ay2_r;
  assign out_zprod = zp2_r;
  assign out_flags = fl2_r;

endmodule

`default_nettype wire

>>> src/vtyp_cordic.sv
// Pipelined CORDIC vectoring unit, one rotation per stage, with a clamping stage at the end.
`timescale 1ns / 1ps
`default_nettype none

module vtyp_cordic
  import vtyp_pkg::*;
#(
  parameter int W      = 44,
  parameter int STAGES = 20,
  parameter int SW     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [W-1:0]  in_x,
  input  logic signed [W-1:0]  in_y,
  input  logic [SW-1:0]        in_side,
  output logic                 out_v,
  output logic [ANG_W-1:0]     out_ang,
  output logic signed [W-1:0]  out_mag,
  output logic [SW-1:0]        out_side
);

  localparam int LAST = STAGES - 1;

  logic signed [W-1:0]     x_r  [STAGES];
  logic signed [W-1:0]     y_r  [STAGES];
  logic signed [ANG_W-1:0] a_r  [STAGES];
  logic                    yz_r [STAGES];
  logic [SW-1:0]           s_r  [STAGES];
  logic                    v_r  [STAGES];

  logic [ANG_W-1:0]        ang_c;
  logic                    vo_r;
  logic [ANG_W-1:0]        ang_r;
  logic signed [W-1:0]     mag_r;
  logic [SW-1:0]           side_r;

  genvar i;
  for (i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] STEP = atan_step(i);

    logic signed [W-1:0]     xp;
    logic signed [W-1:0]     yp;
    logic signed [W-1:0]     dx;
    logic signed [W-1:0]     dy;
    logic signed [ANG_W-1:0] ap;
    logic                    yzp;
    logic                    vp;
    logic [SW-1:0]           sp;
    logic                    rot_pos;

    // Stage inputs: the ports for the first rotation, the previous stage otherwise.
    if (i == 0) begin : g_first
      assign xp  = in_x;
      assign yp  = in_y;
      assign ap  = '0;
      assign yzp = (in_y == '0);
      assign vp  = in_v;
      assign sp  = in_side;
    end else begin : g_next
      assign xp  = x_r[i-1];
      assign yp  = y_r[i-1];
      assign ap  = a_r[i-1];
      assign yzp = yz_r[i-1];
      assign vp  = v_r[i-1];
      assign sp  = s_r[i-1];
    end

    // Rotate towards the x axis; the shifts round towards minus infinity.
    assign dx      = yp >>> i;
    assign dy      = xp >>> i;
    assign rot_pos = !yp[W-1] && (yp != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]  <= rot_pos ? (xp + dx) : (xp - dx);
        y_r[i]  <= rot_pos ? (yp - dy) : (yp + dy);
        a_r[i]  <= rot_pos ? (ap + STEP) : (ap - STEP);
        yz_r[i] <= yzp;
        s_r[i]  <= sp;
      end
    end
  end

  // Clamp the angle to the first quadrant; a zero second operand gives exactly zero.
  always_comb begin
    priority if (yz_r[LAST] || a_r[LAST][ANG_W-1]) begin
      ang_c = '0;
    end else if ($unsigned(a_r[LAST]) > DEG_90) begin
      ang_c = DEG_90;
    end else begin
      ang_c = $unsigned(a_r[LAST]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= ang_c;
      mag_r  <= x_r[LAST];
      side_r <= s_r[LAST];
    end
  end

  assign out_v    = vo_r;
  assign out_ang  = ang_r;
  assign out_mag  = mag_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

>>> src/vtyp_deg_out.sv
// Conversion of both angles to rounded fixed-point degrees by reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module vtyp_deg_out
  import vtyp_pkg::*;
#(
  parameter int F = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  logic [ANG_W-1:0]      yaw_e,
  input  logic [ANG_W-1:0]      pitch_e,
  output logic                  out_v,
  output logic [9+F-1:0]        out_yaw,
  output logic signed [10+F-1:0] out_neg_pitch
);

  // The quotient estimate uses the angle without its low DROP bits and a reciprocal
  // of 2^(44+F) / 1e10; the estimate is at most two below the true quotient.
  localparam int QW     = 9 + F;
  localparam int OW     = 10 + F;
  localparam int NW     = ANG_W + F + 1;
  localparam int DROP   = 16;
  localparam int HW     = ANG_W - DROP;
  localparam int MW     = F + 11;
  localparam int RW     = HW + MW;
  localparam int QSH    = 28;
  localparam int DSH    = 10;
  localparam int DW     = 24;
  localparam int MPW    = QW + DW;
  localparam int TURN   = 360 * (2 ** F);
  localparam logic [NW-1:0]  HALF    = NW'(E10 >> 1);
  localparam logic [NW-1:0]  DIV1    = NW'(E10);
  localparam logic [NW-1:0]  DIV2    = NW'(E10 << 1);
  localparam logic [MW-1:0]  RECIP   = MW'((64'd1 << (44 + F)) / E10);
  localparam logic [DW-1:0]  DIV_ODD = DW'(E10 >> DSH);
  localparam logic [QW-1:0]  TURN_Q  = QW'(TURN);
  localparam logic [OW-1:0]  TURN_O  = OW'(TURN);

  logic          v0_r;
  logic [NW-1:0] ny0_r;
  logic [NW-1:0] np0_r;
  logic [RW-1:0] py0_r;
  logic [RW-1:0] pp0_r;

  logic [QW-1:0]  qy_est;
  logic [QW-1:0]  qp_est;
  logic           v1_r;
  logic [NW-1:0]  ny1_r;
  logic [NW-1:0]  np1_r;
  logic [QW-1:0]  qy1_r;
  logic [QW-1:0]  qp1_r;
  logic [MPW-1:0] my1_r;
  logic [MPW-1:0] mp1_r;

  logic [NW-1:0] ry;
  logic [NW-1:0] rp;
  logic [QW-1:0] yq_c;
  logic [QW-1:0] pq_c;
  logic          v2_r;
  logic [QW-1:0] qy2_r;
  logic [QW-1:0] qp2_r;

  logic [QW-1:0] yq;
  logic [QW-1:0] pq;
  logic [OW-1:0] pe;
  logic          vo_r;
  logic [QW-1:0] yaw_r;
  logic [OW-1:0] negp_r;

  // Stage one: numerators for round half up, and the reciprocal products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ny0_r <= (NW'(yaw_e) << F) + HALF;
      np0_r <= (NW'(pitch_e) << F) + HALF;
      py0_r <= RW'(yaw_e[ANG_W-1:DROP]) * RW'(RECIP);
      pp0_r <= RW'(pitch_e[ANG_W-1:DROP]) * RW'(RECIP);
    end
  end

  // Stage two: quotient estimates and their products with the divisor's odd factor.
  assign qy_est = QW'(py0_r >> QSH);
  assign qp_est = QW'(pp0_r >> QSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ny1_r <= ny0_r;
      np1_r <= np0_r;
      qy1_r <= qy_est;
      qp1_r <= qp_est;
      my1_r <= MPW'(qy_est) * MPW'(DIV_ODD);
      mp1_r <= MPW'(qp_est) * MPW'(DIV_ODD);
    end
  end

  // Stage three: the remainder decides whether the estimate stays or rises by one or two.
  always_comb begin
    ry = ny1_r - NW'({my1_r, {DSH{1'b0}}});
    rp = np1_r - NW'({mp1_r, {DSH{1'b0}}});
    priority if (ry >= DIV2) begin
      yq_c = qy1_r + QW'(2);
    end else if (ry >= DIV1) begin
      yq_c = qy1_r + QW'(1);
    end else begin
      yq_c = qy1_r;
    end
    priority if (rp >= DIV2) begin
      pq_c = qp1_r + QW'(2);
    end else if (rp >= DIV1) begin
      pq_c = qp1_r + QW'(1);
    end else begin
      pq_c = qp1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qy2_r <= yq_c;
      qp2_r <= pq_c;
    end
  end

  // A result that rounds up to a full turn wraps to zero; pitch is then negated.
  assign yq = qy2_r;
  assign pq = qp2_r;
  assign pe = OW'(pq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r  <= (yq >= TURN_Q) ? (yq - TURN_Q) : yq;
      negp_r <= (pq >= TURN_Q) ? (TURN_O - pe) : ('0 - pe);
    end
  end

  assign out_v         = vo_r;
  assign out_yaw       = yaw_r;
  assign out_neg_pitch = $signed(negp_r);

endmodule

`default_nettype wire
